### src/psg_pkg.sv
// Types, register map, volume table and per-tick update functions for the
// three-voice sound generator. No dependencies; used by the top level.
`default_nettype none

package psg_pkg;

    localparam int REG_COUNT  = 14;
    localparam int ADDR_W     = 4;
    localparam int SAMPLE_W   = 15;
    localparam int VOL_MAX    = 21845;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [ADDR_W-1:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [ADDR_W-1:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [ADDR_W-1:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [ADDR_W-1:0] REG_TONE_B_COARSE = 4'd3;
    localparam logic [ADDR_W-1:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [ADDR_W-1:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [ADDR_W-1:0] REG_NOISE_PERIOD  = 4'd6;
    localparam logic [ADDR_W-1:0] REG_MIXER         = 4'd7;
    localparam logic [ADDR_W-1:0] REG_VOL_A         = 4'd8;
    localparam logic [ADDR_W-1:0] REG_VOL_B         = 4'd9;
    localparam logic [ADDR_W-1:0] REG_VOL_C         = 4'd10;
    localparam logic [ADDR_W-1:0] REG_ENV_FINE      = 4'd11;
    localparam logic [ADDR_W-1:0] REG_ENV_COARSE    = 4'd12;
    localparam logic [ADDR_W-1:0] REG_ENV_SHAPE     = 4'd13;

    localparam logic [7:0] ENV_SHAPE_IGNORE = 8'hff;
    localparam int         ENV_ATTACK_BIT   = 2;
    localparam int         VOL_ENV_BIT      = 4;
    localparam logic [15:0] NOISE_SEED      = 16'hffff;

    localparam logic [3:0] ENV_DECAY_LOW_A  = 4'd0;
    localparam logic [3:0] ENV_DECAY_LOW_B  = 4'd1;
    localparam logic [3:0] ENV_DECAY_LOW_C  = 4'd2;
    localparam logic [3:0] ENV_DECAY_LOW_D  = 4'd3;
    localparam logic [3:0] ENV_ATTACK_LOW_A = 4'd4;
    localparam logic [3:0] ENV_ATTACK_LOW_B = 4'd5;
    localparam logic [3:0] ENV_ATTACK_LOW_C = 4'd6;
    localparam logic [3:0] ENV_ATTACK_LOW_D = 4'd7;
    localparam logic [3:0] ENV_SAW_DOWN     = 4'd8;
    localparam logic [3:0] ENV_DECAY_LOW_E  = 4'd9;
    localparam logic [3:0] ENV_TRI_DOWN     = 4'd10;
    localparam logic [3:0] ENV_DECAY_HIGH   = 4'd11;
    localparam logic [3:0] ENV_SAW_UP       = 4'd12;
    localparam logic [3:0] ENV_ATTACK_HIGH  = 4'd13;
    localparam logic [3:0] ENV_TRI_UP       = 4'd14;
    localparam logic [3:0] ENV_ATTACK_LOW_E = 4'd15;

    typedef logic [REG_COUNT-1:0][7:0] psg_regs_t;

    typedef struct packed {
        logic [2:0][12:0] tone_count;
        logic [2:0]       tone_level;
        logic             half_div;
        logic [15:0]      noise_shift;
        logic             noise_prev;
        logic             noise_level;
        logic [4:0]       noise_count;
        logic [15:0]      env_count;
        logic [3:0]       env_level;
        logic             env_rising;
    } psg_state_t;

    localparam psg_state_t STATE_RESET = '{
        tone_count:  '0,
        tone_level:  '0,
        half_div:    1'b0,
        noise_shift: NOISE_SEED,
        noise_prev:  1'b0,
        noise_level: 1'b0,
        noise_count: '0,
        env_count:   '0,
        env_level:   '0,
        env_rising:  1'b0
    };

    typedef struct packed {
        logic [3:0] level;
        logic       rising;
    } psg_env_t;

    function automatic logic [SAMPLE_W-1:0] psg_vol(input logic [3:0] lv);
        logic [SAMPLE_W-1:0] v;
        case (lv)
            4'd0:    v = 15'd0;
            4'd1:    v = 15'd278;
            4'd2:    v = 15'd404;
            4'd3:    v = 15'd591;
            4'd4:    v = 15'd873;
            4'd5:    v = 15'd1291;
            4'd6:    v = 15'd1799;
            4'd7:    v = 15'd2941;
            4'd8:    v = 15'd3464;
            4'd9:    v = 15'd5568;
            4'd10:   v = 15'd7779;
            4'd11:   v = 15'd9764;
            4'd12:   v = 15'd12323;
            4'd13:   v = 15'd15473;
            4'd14:   v = 15'd18398;
            default: v = 15'd21845;
        endcase
        return v;
    endfunction

    function automatic psg_env_t psg_env_step(input logic [3:0] shape,
                                              input psg_env_t e);
        psg_env_t n;
        n = e;
        case (shape)
            ENV_DECAY_LOW_A, ENV_DECAY_LOW_B, ENV_DECAY_LOW_C, ENV_DECAY_LOW_D,
            ENV_DECAY_LOW_E:
            begin
                if (e.level != 4'd0)
                    n.level = e.level - 4'd1;
            end
            ENV_ATTACK_LOW_A, ENV_ATTACK_LOW_B, ENV_ATTACK_LOW_C, ENV_ATTACK_LOW_D,
            ENV_ATTACK_LOW_E:
            begin
                if (e.rising)
                begin
                    if (e.level == 4'd15)
                    begin
                        n.level  = 4'd0;
                        n.rising = 1'b0;
                    end
                    else
                        n.level = e.level + 4'd1;
                end
            end
            ENV_SAW_DOWN:
                n.level = e.level - 4'd1;
            ENV_TRI_DOWN, ENV_TRI_UP:
            begin
                if (!e.rising)
                begin
                    if (e.level == 4'd0)
                        n.rising = 1'b1;
                    else
                        n.level = e.level - 4'd1;
                end
                else
                begin
                    if (e.level == 4'd15)
                        n.rising = 1'b0;
                    else
                        n.level = e.level + 4'd1;
                end
            end
            ENV_DECAY_HIGH:
            begin
                if (!e.rising)
                begin
                    if (e.level == 4'd0)
                    begin
                        n.level  = 4'd15;
                        n.rising = 1'b1;
                    end
                    else
                        n.level = e.level - 4'd1;
                end
            end
            ENV_SAW_UP:
                n.level = e.level + 4'd1;
            default:
            begin
                if (e.level != 4'd15)
                    n.level = e.level + 4'd1;
            end
        endcase
        return n;
    endfunction

    function automatic psg_state_t psg_tick(input psg_state_t s, input psg_regs_t r);
        psg_state_t n;
        logic [11:0] period;
        logic        fb;
        logic [4:0]  nc;
        logic [15:0] env_period;
        logic [16:0] env_next;
        psg_env_t    e;
        n = s;
        n.half_div = ~s.half_div;
        for (int ch = 0; ch < 3; ch++)
        begin
            period = {r[2*ch+1][3:0], r[2*ch]};
            if (s.tone_count[ch] >= {1'b0, period})
            begin
                n.tone_count[ch] = 13'd0;
                n.tone_level[ch] = ~s.tone_level[ch];
            end
            n.tone_count[ch] = n.tone_count[ch] + 13'd1;
        end
        if (n.half_div)
        begin
            if (s.noise_count == 5'd0)
            begin
                fb = s.noise_prev ^ s.noise_shift[13] ^ 1'b1;
                n.noise_prev  = s.noise_shift[15];
                n.noise_level = s.noise_shift[15];
                n.noise_shift = {s.noise_shift[14:0], fb};
            end
            nc = s.noise_count + 5'd1;
            n.noise_count = (nc >= r[REG_NOISE_PERIOD][4:0]) ? 5'd0 : nc;
            if (s.env_count == 16'd0)
            begin
                e = psg_env_step(r[REG_ENV_SHAPE][3:0], psg_env_t'{level: s.env_level,
                                                                   rising: s.env_rising});
                n.env_level  = e.level;
                n.env_rising = e.rising;
            end
            env_period = {r[REG_ENV_COARSE], r[REG_ENV_FINE]};
            env_next   = {1'b0, s.env_count} + 17'd1;
            n.env_count = (env_next >= {1'b0, env_period}) ? 16'd0 : env_next[15:0];
        end
        return n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] psg_channel_vol(input psg_state_t s,
                                                            input psg_regs_t r,
                                                            input int ch);
        logic [7:0] vreg;
        logic       t;
        logic       nz;
        logic [3:0] lv;
        vreg = r[8+ch];
        t    = s.tone_level[ch] | r[REG_MIXER][ch];
        nz   = s.noise_level | r[REG_MIXER][ch+3];
        if (vreg[VOL_ENV_BIT])
            lv = s.env_level;
        else
            lv = (t & nz) ? vreg[3:0] : 4'd0;
        return psg_vol(lv);
    endfunction

endpackage

`default_nettype wire

### src/psg_three_voice_sound_generator.sv
// Three-voice sound generator top level: input item register, tick update and
// per-channel sums, divide and stereo mix into the output register. Uses psg_pkg.
//
// Usage:
//   The item channel (item_valid/item_ready) carries either a register write
//   (mode 0: reg_addr, reg_data) or a sample request (mode 1). Writes return
//   nothing; each sample request returns one item on the sample channel
//   (sample_valid/sample_ready) with left_sample and right_sample.
//   Throughput is one item per cycle: the whole run of TICKS_PER_SAMPLE chip
//   ticks for a request is evaluated in a single pass of logic between the
//   input item register and the sum register.
//   A request passes the input register, the sum register and the output
//   register, in that order, before it shows sample_valid.
//   Writes take effect for any request accepted after them.
//   When the receiver stalls, results hold in the sum and output registers and
//   item_ready drops only once those are full; writes keep flowing past a
//   stalled result since they do not need a result slot.
//   Reset clears all sound registers and generator state (noise shift register
//   to all ones) and empties the pipeline; no clearing pass is needed.
`default_nettype none

module psg_three_voice_sound_generator #(
    parameter int TICKS_PER_SAMPLE = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic                           mode,
    input  wire logic [psg_pkg::ADDR_W-1:0]     reg_addr,
    input  wire logic [7:0]                     reg_data,
    output logic                                sample_valid,
    input  wire logic                           sample_ready,
    output logic [psg_pkg::SAMPLE_W-1:0]        left_sample,
    output logic [psg_pkg::SAMPLE_W-1:0]        right_sample
);

    localparam int SUM_W     = $clog2(psg_pkg::VOL_MAX * TICKS_PER_SAMPLE + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(TICKS_PER_SAMPLE);
    localparam longint unsigned DIV_MULT =
        ((64'd1 << DIV_SHIFT) + TICKS_PER_SAMPLE - 1) / TICKS_PER_SAMPLE;
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam int SW        = psg_pkg::SAMPLE_W;

    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    logic [psg_pkg::ADDR_W-1:0]  s1_addr_reg;
    logic [7:0]                  s1_data_reg;

    logic                        s2_valid_reg;
    logic [2:0][SUM_W-1:0]       s2_sum_reg;

    logic                        sample_valid_reg;
    logic [SW-1:0]               left_reg;
    logic [SW-1:0]               right_reg;

    psg_pkg::psg_state_t         state_reg;
    psg_pkg::psg_state_t         state_next;
    psg_pkg::psg_regs_t          regs_reg;
    psg_pkg::psg_regs_t          regs_next;

    psg_pkg::psg_state_t         run_state;
    logic [2:0][SUM_W-1:0]       run_sum;

    logic                        out_free;
    logic                        s2_free;
    logic                        s1_fire;
    logic                        s1_sample;

    logic [2:0][PROD_W-1:0]      prod;
    logic [2:0][SW-1:0]          avg;
    logic [SW:0]                 left_next;
    logic [SW:0]                 right_next;

    assign out_free   = !sample_valid_reg || sample_ready;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_fire    = s1_valid_reg && (s1_mode_reg == psg_pkg::MODE_WRITE || s2_free);
    assign s1_sample  = s1_fire && (s1_mode_reg == psg_pkg::MODE_SAMPLE);
    assign item_ready = !s1_valid_reg || s1_fire;

    assign sample_valid = sample_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

    // Tick run for one sample request
    always_comb
    begin
        run_state = state_reg;
        run_sum   = '0;
        for (int i = 0; i < TICKS_PER_SAMPLE; i++)
        begin
            run_state = psg_pkg::psg_tick(run_state, regs_reg);
            for (int ch = 0; ch < 3; ch++)
                run_sum[ch] = run_sum[ch]
                            + SUM_W'(psg_pkg::psg_channel_vol(run_state, regs_reg, ch));
        end
    end

    // Register write and state advance
    always_comb
    begin
        state_next = state_reg;
        regs_next  = regs_reg;
        if (s1_sample)
            state_next = run_state;
        else if (s1_fire && s1_addr_reg < psg_pkg::ADDR_W'(psg_pkg::REG_COUNT)
                 && !(s1_addr_reg == psg_pkg::REG_ENV_SHAPE
                      && s1_data_reg == psg_pkg::ENV_SHAPE_IGNORE))
        begin
            case (s1_addr_reg)
                psg_pkg::REG_TONE_A_COARSE, psg_pkg::REG_TONE_B_COARSE,
                psg_pkg::REG_TONE_C_COARSE:
                    regs_next[s1_addr_reg] = {4'd0, s1_data_reg[3:0]};
                psg_pkg::REG_NOISE_PERIOD, psg_pkg::REG_VOL_A, psg_pkg::REG_VOL_B,
                psg_pkg::REG_VOL_C:
                    regs_next[s1_addr_reg] = {3'd0, s1_data_reg[4:0]};
                psg_pkg::REG_ENV_SHAPE:
                begin
                    regs_next[s1_addr_reg] = {4'd0, s1_data_reg[3:0]};
                    state_next.env_count   = 16'd0;
                    state_next.env_rising  = s1_data_reg[psg_pkg::ENV_ATTACK_BIT];
                    state_next.env_level   = s1_data_reg[psg_pkg::ENV_ATTACK_BIT]
                                           ? 4'd0 : 4'd15;
                end
                default:
                    regs_next[s1_addr_reg] = s1_data_reg;
            endcase
        end
    end

    // Average and stereo mix
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PROD_W'(s2_sum_reg[ch]) * PROD_W'(DIV_MULT);
            avg[ch]  = prod[ch][DIV_SHIFT +: SW];
        end
        left_next  = {1'b0, avg[0]} + {2'b00, avg[1][SW-1:1]};
        right_next = {1'b0, avg[2]} + {2'b00, avg[1][SW-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            s2_valid_reg          <= 1'b0;
            sample_valid_reg      <= 1'b0;
            regs_reg              <= '0;
            state_reg             <= psg_pkg::STATE_RESET;
        end
        else
        begin
            regs_reg  <= regs_next;
            state_reg <= state_next;
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (s2_free)
                s2_valid_reg <= s1_sample;
            if (out_free)
                sample_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_mode_reg <= mode;
            s1_addr_reg <= reg_addr;
            s1_data_reg <= reg_data;
        end
        if (s1_sample)
            s2_sum_reg <= run_sum;
        if (s2_valid_reg && out_free)
        begin
            left_reg  <= left_next[SW]  ? {SW{1'b1}} : left_next[SW-1:0];
            right_reg <= right_next[SW] ? {SW{1'b1}} : right_next[SW-1:0];
        end
    end

    a_tone_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.tone_count[0][12] || state_reg.tone_count[1][12]
          || state_reg.tone_count[2][12]))
        else $error("tone divider count out of range");

    a_sample_reaches_sum: assert property (@(posedge clk) disable iff (!rst_n)
        s1_sample |=> s2_valid_reg)
        else $error("sample request lost before sum register");

    a_sum_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_free) |=> s2_valid_reg)
        else $error("pending sum dropped during stall");

    a_env_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_mode_reg == psg_pkg::MODE_WRITE
         && s1_addr_reg == psg_pkg::REG_ENV_SHAPE
         && s1_data_reg != psg_pkg::ENV_SHAPE_IGNORE)
        |=> (state_reg.env_count == 16'd0))
        else $error("envelope not restarted on shape write");

endmodule

`default_nettype wire

### verif/psg_three_voice_sound_generator_test.sv
// Self-checking test of the three-voice sound generator: register writes and
// sample requests go in through the item channel, stereo samples are checked.
// Depends on psg_pkg and psg_three_voice_sound_generator.
`default_nettype none

module psg_three_voice_sound_generator_test;

    localparam int TICKS       = 5;
    localparam int HOLD_CYCLES = 200;

    localparam int unsigned LOUDNESS [16] = '{
        0 / 3, 836 / 3, 1212 / 3, 1773 / 3, 2619 / 3, 3875 / 3, 5397 / 3, 8823 / 3,
        10392 / 3, 16706 / 3, 23339 / 3, 29292 / 3, 36969 / 3, 46421 / 3, 55195 / 3,
        65535 / 3
    };

    typedef struct {
        logic [psg_pkg::SAMPLE_W-1:0] left;
        logic [psg_pkg::SAMPLE_W-1:0] right;
    } stereo_t;

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_ready;
    logic                         mode;
    logic [psg_pkg::ADDR_W-1:0]   reg_addr;
    logic [7:0]                   reg_data;
    logic                         sample_valid;
    logic                         sample_ready;
    logic [psg_pkg::SAMPLE_W-1:0] left_sample;
    logic [psg_pkg::SAMPLE_W-1:0] right_sample;

    logic [7:0]  chip_regs [psg_pkg::REG_COUNT];
    logic [12:0] tone_cnt [3];
    logic        tone_lvl [3];
    logic        half_phase;
    logic [15:0] noise_lfsr;
    logic        noise_prev;
    logic        noise_out;
    logic [4:0]  noise_cnt;
    logic [15:0] env_cnt;
    logic [3:0]  env_lvl;
    logic        env_up;

    stereo_t expected_samples [$];
    stereo_t want;
    int      failures;
    bit      gaps_on;
    bit      stalls_on;
    bit      hold_output;

    psg_three_voice_sound_generator #(
        .TICKS_PER_SAMPLE(TICKS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .mode(mode),
        .reg_addr(reg_addr),
        .reg_data(reg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .left_sample(left_sample),
        .right_sample(right_sample)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic void reset_model();
        for (int i = 0; i < psg_pkg::REG_COUNT; i++)
            chip_regs[i] = 8'd0;
        for (int ch = 0; ch < 3; ch++)
        begin
            tone_cnt[ch] = 13'd0;
            tone_lvl[ch] = 1'b0;
        end
        half_phase = 1'b0;
        noise_lfsr = psg_pkg::NOISE_SEED;
        noise_prev = 1'b0;
        noise_out  = 1'b0;
        noise_cnt  = 5'd0;
        env_cnt    = 16'd0;
        env_lvl    = 4'd0;
        env_up     = 1'b0;
    endfunction

    function automatic void store_register(input logic [3:0] a, input logic [7:0] d);
        logic [7:0] v;
        v = d;
        if (a > psg_pkg::REG_ENV_SHAPE)
            return;
        if (a == psg_pkg::REG_ENV_SHAPE && d == psg_pkg::ENV_SHAPE_IGNORE)
            return;
        case (a)
            psg_pkg::REG_TONE_A_COARSE, psg_pkg::REG_TONE_B_COARSE,
            psg_pkg::REG_TONE_C_COARSE:
                v = d & 8'h0f;
            psg_pkg::REG_NOISE_PERIOD, psg_pkg::REG_VOL_A, psg_pkg::REG_VOL_B,
            psg_pkg::REG_VOL_C:
                v = d & 8'h1f;
            psg_pkg::REG_ENV_SHAPE:
            begin
                v = d & 8'h0f;
                env_cnt = 16'd0;
                if (v[psg_pkg::ENV_ATTACK_BIT])
                begin
                    env_lvl = 4'd0;
                    env_up  = 1'b1;
                end
                else
                begin
                    env_lvl = 4'd15;
                    env_up  = 1'b0;
                end
            end
            default:
                ;
        endcase
        chip_regs[a] = v;
    endfunction

    function automatic void advance_envelope();
        int lv;
        lv = env_lvl;
        case (chip_regs[psg_pkg::REG_ENV_SHAPE][3:0])
            psg_pkg::ENV_DECAY_LOW_A, psg_pkg::ENV_DECAY_LOW_B, psg_pkg::ENV_DECAY_LOW_C,
            psg_pkg::ENV_DECAY_LOW_D, psg_pkg::ENV_DECAY_LOW_E:
            begin
                if (lv > 0)
                    lv--;
            end
            psg_pkg::ENV_ATTACK_LOW_A, psg_pkg::ENV_ATTACK_LOW_B, psg_pkg::ENV_ATTACK_LOW_C,
            psg_pkg::ENV_ATTACK_LOW_D, psg_pkg::ENV_ATTACK_LOW_E:
            begin
                if (env_up)
                begin
                    lv++;
                    if (lv > 15)
                    begin
                        lv = 0;
                        env_up = 1'b0;
                    end
                end
            end
            psg_pkg::ENV_SAW_DOWN:
            begin
                lv--;
                if (lv < 0)
                    lv = 15;
            end
            psg_pkg::ENV_TRI_DOWN, psg_pkg::ENV_TRI_UP:
            begin
                if (!env_up)
                begin
                    lv--;
                    if (lv < 0)
                    begin
                        lv = 0;
                        env_up = 1'b1;
                    end
                end
                else
                begin
                    lv++;
                    if (lv > 15)
                    begin
                        lv = 15;
                        env_up = 1'b0;
                    end
                end
            end
            psg_pkg::ENV_DECAY_HIGH:
            begin
                if (!env_up)
                begin
                    lv--;
                    if (lv < 0)
                    begin
                        lv = 15;
                        env_up = 1'b1;
                    end
                end
            end
            psg_pkg::ENV_SAW_UP:
            begin
                lv++;
                if (lv > 15)
                    lv = 0;
            end
            default:
            begin
                if (lv < 15)
                    lv++;
            end
        endcase
        env_lvl = lv[3:0];
    endfunction

    function automatic void clock_noise_envelope();
        logic        fb;
        logic [15:0] env_period;
        if (noise_cnt == 5'd0)
        begin
            fb = noise_prev ^ noise_lfsr[13] ^ 1'b1;
            noise_prev = noise_lfsr[15];
            noise_out  = noise_lfsr[15];
            noise_lfsr = {noise_lfsr[14:0], fb};
        end
        noise_cnt = noise_cnt + 5'd1;
        if (noise_cnt >= chip_regs[psg_pkg::REG_NOISE_PERIOD][4:0])
            noise_cnt = 5'd0;
        if (env_cnt == 16'd0)
            advance_envelope();
        env_period = {chip_regs[psg_pkg::REG_ENV_COARSE], chip_regs[psg_pkg::REG_ENV_FINE]};
        if ({1'b0, env_cnt} + 17'd1 >= {1'b0, env_period})
            env_cnt = 16'd0;
        else
            env_cnt = env_cnt + 16'd1;
    endfunction

    function automatic int unsigned voice_loudness(input int ch);
        logic [7:0] vreg;
        logic       t;
        logic       n;
        logic [3:0] lv;
        vreg = chip_regs[psg_pkg::REG_VOL_A + ch];
        t = tone_lvl[ch] | chip_regs[psg_pkg::REG_MIXER][ch];
        n = noise_out | chip_regs[psg_pkg::REG_MIXER][ch + 3];
        if (vreg[psg_pkg::VOL_ENV_BIT])
            lv = env_lvl;
        else
            lv = (t & n) ? vreg[3:0] : 4'd0;
        return LOUDNESS[lv];
    endfunction

    function automatic stereo_t render_sample();
        int unsigned acc [3];
        int unsigned l;
        int unsigned r;
        logic [11:0] period;
        stereo_t     s;
        for (int ch = 0; ch < 3; ch++)
            acc[ch] = 0;
        for (int i = 0; i < TICKS; i++)
        begin
            half_phase = ~half_phase;
            for (int ch = 0; ch < 3; ch++)
            begin
                period = {chip_regs[2 * ch + 1][3:0], chip_regs[2 * ch]};
                if (tone_cnt[ch] >= {1'b0, period})
                begin
                    tone_cnt[ch] = 13'd0;
                    tone_lvl[ch] = ~tone_lvl[ch];
                end
                tone_cnt[ch] = tone_cnt[ch] + 13'd1;
            end
            if (half_phase)
                clock_noise_envelope();
            for (int ch = 0; ch < 3; ch++)
                acc[ch] += voice_loudness(ch);
        end
        for (int ch = 0; ch < 3; ch++)
            acc[ch] = acc[ch] / TICKS;
        l = acc[0] + acc[1] / 2;
        r = acc[2] + acc[1] / 2;
        if (l > 32767)
            l = 32767;
        if (r > 32767)
            r = 32767;
        s.left  = l[psg_pkg::SAMPLE_W-1:0];
        s.right = r[psg_pkg::SAMPLE_W-1:0];
        return s;
    endfunction

    task automatic send_item(input logic m, input logic [3:0] a, input logic [7:0] d);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        reg_addr   <= a;
        reg_data   <= d;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (m == psg_pkg::MODE_SAMPLE)
            expected_samples.push_back(render_sample());
        else
            store_register(a, d);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample left_sample=%0d right_sample=%0d",
                       left_sample, right_sample);
                failures++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (left_sample !== want.left)
                begin
                    $error("left_sample expected %0d actual %0d", want.left, left_sample);
                    failures++;
                end
                if (right_sample !== want.right)
                begin
                    $error("right_sample expected %0d actual %0d", want.right, right_sample);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int stall;
        sample_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                sample_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            stall = stalls_on ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                sample_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sample_ready <= 1'b1;
            @(posedge clk);
            while (!sample_valid)
                @(posedge clk);
        end
    end

    task automatic test_register_map();
        send_item(psg_pkg::MODE_SAMPLE, 4'd15, 8'hff);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_TONE_A_FINE, 8'hff);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_TONE_A_COARSE, 8'hff);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_TONE_B_FINE, 8'h00);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_TONE_B_COARSE, 8'hff);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_NOISE_PERIOD, 8'hff);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_MIXER, 8'h00);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_VOL_A, 8'hff);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_VOL_B, 8'h0f);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_VOL_C, 8'h10);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_ENV_FINE, 8'h00);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_ENV_COARSE, 8'h00);
        send_item(psg_pkg::MODE_WRITE, 4'd14, 8'hff);
        send_item(psg_pkg::MODE_WRITE, 4'd15, 8'h00);
        send_item(psg_pkg::MODE_SAMPLE, 4'd0, 8'h00);
    endtask

    task automatic test_envelope_restart();
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_ENV_SHAPE, psg_pkg::ENV_SHAPE_IGNORE);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_ENV_SHAPE, {4'd0, psg_pkg::ENV_TRI_UP});
        send_item(psg_pkg::MODE_SAMPLE, 4'd7, 8'h5a);
        send_item(psg_pkg::MODE_SAMPLE, 4'd8, 8'ha5);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_ENV_SHAPE, {4'd0, psg_pkg::ENV_SAW_DOWN});
        send_item(psg_pkg::MODE_SAMPLE, 4'd3, 8'h3c);
        send_item(psg_pkg::MODE_SAMPLE, 4'd12, 8'hc3);
        send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_MIXER, 8'hff);
        send_item(psg_pkg::MODE_SAMPLE, 4'd0, 8'h00);
    endtask

    task automatic test_output_backpressure();
        gaps_on     = 1'b0;
        stalls_on   = 1'b0;
        hold_output = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 4 == 3)
                send_item(psg_pkg::MODE_WRITE, psg_pkg::REG_VOL_B, 8'($urandom_range(0, 255)));
            else
                send_item(psg_pkg::MODE_SAMPLE, 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic(input int count);
        int         kind;
        logic [3:0] a;
        logic [7:0] d;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                gaps_on   = 1'($urandom_range(0, 1));
                stalls_on = 1'($urandom_range(0, 1));
            end
            kind = $urandom_range(0, 99);
            a = 4'($urandom_range(0, 15));
            d = 8'($urandom_range(0, 255));
            if (kind < 55)
                send_item(psg_pkg::MODE_SAMPLE, a, d);
            else if (kind < 92)
            begin
                a = 4'($urandom_range(0, psg_pkg::REG_COUNT - 1));
                case (a)
                    psg_pkg::REG_TONE_A_COARSE, psg_pkg::REG_TONE_B_COARSE,
                    psg_pkg::REG_TONE_C_COARSE, psg_pkg::REG_ENV_FINE:
                    begin
                        if ($urandom_range(0, 3) != 0)
                            d = 8'($urandom_range(0, 3));
                    end
                    psg_pkg::REG_ENV_COARSE:
                    begin
                        if ($urandom_range(0, 7) != 0)
                            d = 8'd0;
                    end
                    psg_pkg::REG_ENV_SHAPE:
                    begin
                        if ($urandom_range(0, 3) != 0)
                            d = d & 8'h0f;
                    end
                    default:
                        ;
                endcase
                send_item(psg_pkg::MODE_WRITE, a, d);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    a = psg_pkg::REG_ENV_SHAPE;
                    d = psg_pkg::ENV_SHAPE_IGNORE;
                end
                send_item(psg_pkg::MODE_WRITE, a, d);
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        mode        <= psg_pkg::MODE_WRITE;
        reg_addr    <= 4'd0;
        reg_data    <= 8'd0;
        gaps_on     = 1'b0;
        stalls_on   = 1'b0;
        hold_output = 1'b0;
        failures    = 0;
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_map();
        test_envelope_restart();
        test_output_backpressure();
        test_random_traffic(1130);
        item_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
